/* hw/rtl/cfp_pkg.sv */
// ----------------------------------------------------------------------------
// cfp_pkg
// Shared types, register indexes, status codes and the CRC16-CCITT byte step
// for the framed-byte parser.
// ----------------------------------------------------------------------------
package cfp_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SYNC_V1       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_V2       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_LIMIT = 2'd2;

  localparam logic [7:0]  SYNC_V1_RESET       = 8'hC0;
  localparam logic [7:0]  SYNC_V2_RESET       = 8'hC1;
  localparam logic [15:0] PAYLOAD_LIMIT_RESET = 16'd6144;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  typedef enum logic [1:0] {
    ST_BUSY   = 2'd0,
    ST_GOOD   = 2'd1,
    ST_LENERR = 2'd2,
    ST_CRCERR = 2'd3
  } status_t;

  typedef enum logic [7:0] {
    PH_SYNC    = 8'b0000_0001,
    PH_CMD     = 8'b0000_0010,
    PH_SEQ     = 8'b0000_0100,
    PH_LEN_LO  = 8'b0000_1000,
    PH_LEN_HI  = 8'b0001_0000,
    PH_PAYLOAD = 8'b0010_0000,
    PH_CRC_LO  = 8'b0100_0000,
    PH_CRC_HI  = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [7:0]  sync_v1;
    logic [7:0]  sync_v2;
    logic [15:0] payload_limit;
  } cfg_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* hw/rtl/crc_checked_frame_parser.sv */
// ----------------------------------------------------------------------------
// crc_checked_frame_parser
// Sync / length / CRC16-CCITT frame parser, one received byte per item.
// ----------------------------------------------------------------------------
// Each accepted byte yields one result item in the next cycle; a byte is taken
// in every cycle while the result register is empty or being taken, so the
// sustained rate is one byte per clock. The CRC update over the byte and the
// phase decode sit between the parser state and the result register.
module crc_checked_frame_parser import cfp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_data_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_frame_status,
  output logic                  out_frame_version,
  output logic [7:0]            out_command_code,
  output logic [7:0]            out_sequence_number,
  output logic [15:0]           out_payload_length,
  output logic [7:0]            out_payload_byte,
  output logic                  out_payload_valid,
  output logic [15:0]           out_payload_index
);

  cfg_t cfg;

  cfp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  phase_t      phase_r,    phase_nxt;
  logic        version_r,  version_nxt;
  logic [7:0]  command_r,  command_nxt;
  logic [7:0]  sequence_r, sequence_nxt;
  logic [15:0] length_r,   length_nxt;
  logic [15:0] count_r,    count_nxt;
  logic [15:0] crc_r,      crc_nxt;
  logic [7:0]  crc_lo_r,   crc_lo_nxt;

  status_t     status;
  logic [7:0]  pbyte;
  logic        pvalid;
  logic [15:0] pindex;
  logic [15:0] crc_step;
  logic [15:0] len_full;
  logic        in_accept;

  logic        out_valid_r;
  logic [1:0]  status_r;
  logic        ver_out_r;
  logic [7:0]  cmd_out_r;
  logic [7:0]  seq_out_r;
  logic [15:0] len_out_r;
  logic [7:0]  pbyte_r;
  logic        pvalid_r;
  logic [15:0] pindex_r;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;
  assign crc_step  = crc_byte(crc_r, in_data_byte);
  assign len_full  = {in_data_byte, length_r[7:0]};

  always_comb begin
    phase_nxt    = phase_r;
    version_nxt  = version_r;
    command_nxt  = command_r;
    sequence_nxt = sequence_r;
    length_nxt   = length_r;
    count_nxt    = count_r;
    crc_nxt      = crc_r;
    crc_lo_nxt   = crc_lo_r;
    status       = ST_BUSY;
    pbyte        = 8'h00;
    pvalid       = 1'b0;
    pindex       = 16'h0000;
    unique case (phase_r)
      PH_SYNC: begin
        if (in_data_byte == cfg.sync_v1 || in_data_byte == cfg.sync_v2) begin
          version_nxt  = (in_data_byte != cfg.sync_v1);
          command_nxt  = 8'h00;
          sequence_nxt = 8'h00;
          length_nxt   = 16'h0000;
          count_nxt    = 16'h0000;
          crc_nxt      = CRC_INIT;
          phase_nxt    = PH_CMD;
        end
      end
      PH_CMD: begin
        command_nxt = in_data_byte;
        crc_nxt     = crc_step;
        phase_nxt   = version_r ? PH_SEQ : PH_LEN_LO;
      end
      PH_SEQ: begin
        sequence_nxt = in_data_byte;
        crc_nxt      = crc_step;
        phase_nxt    = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        length_nxt = {8'h00, in_data_byte};
        crc_nxt    = crc_step;
        phase_nxt  = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        length_nxt = len_full;
        crc_nxt    = crc_step;
        count_nxt  = 16'h0000;
        if (len_full > cfg.payload_limit) begin
          status    = ST_LENERR;
          phase_nxt = PH_SYNC;
        end else begin
          phase_nxt = (len_full == 16'h0000) ? PH_CRC_LO : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        pbyte     = in_data_byte;
        pvalid    = 1'b1;
        pindex    = count_r;
        crc_nxt   = crc_step;
        count_nxt = count_r + 16'd1;
        if (count_nxt >= length_r || count_nxt == 16'h0000) begin
          phase_nxt = PH_CRC_LO;
        end
      end
      PH_CRC_LO: begin
        crc_lo_nxt = in_data_byte;
        phase_nxt  = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        status    = ({in_data_byte, crc_lo_r} == crc_r) ? ST_GOOD : ST_CRCERR;
        phase_nxt = PH_SYNC;
      end
      default: begin
        phase_nxt = PH_SYNC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SYNC;
      version_r   <= 1'b0;
      command_r   <= 8'h00;
      sequence_r  <= 8'h00;
      length_r    <= 16'h0000;
      count_r     <= 16'h0000;
      crc_r       <= CRC_INIT;
      crc_lo_r    <= 8'h00;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        phase_r    <= phase_nxt;
        version_r  <= version_nxt;
        command_r  <= command_nxt;
        sequence_r <= sequence_nxt;
        length_r   <= length_nxt;
        count_r    <= count_nxt;
        crc_r      <= crc_nxt;
        crc_lo_r   <= crc_lo_nxt;
      end
      if (in_accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      status_r  <= status;
      ver_out_r <= version_nxt;
      cmd_out_r <= command_nxt;
      seq_out_r <= sequence_nxt;
      len_out_r <= length_nxt;
      pbyte_r   <= pbyte;
      pvalid_r  <= pvalid;
      pindex_r  <= pindex;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_frame_status    = status_r;
  assign out_frame_version   = ver_out_r;
  assign out_command_code    = cmd_out_r;
  assign out_sequence_number = seq_out_r;
  assign out_payload_length  = len_out_r;
  assign out_payload_byte    = pbyte_r;
  assign out_payload_valid   = pvalid_r;
  assign out_payload_index   = pindex_r;

  a_payload_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && pvalid_r |-> status_r == ST_BUSY)
    else $error("payload item carries a final status");

  a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !pvalid_r |-> pbyte_r == 8'h00 && pindex_r == 16'h0000)
    else $error("non-payload item carries payload data");

  a_lenerr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && phase_r == PH_LEN_HI && status == ST_LENERR
    |=> phase_r == PH_SYNC && status_r == ST_LENERR)
    else $error("length error did not return parser to sync hunt");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result register not empty after reset");

endmodule

/* hw/rtl/cfp_cfg_regs.sv */
// ----------------------------------------------------------------------------
// cfp_cfg_regs
// Configuration register bank: sync bytes and payload length limit.
// ----------------------------------------------------------------------------
module cfp_cfg_regs import cfp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_SYNC_V1:       cfg_nxt.sync_v1       = cfg_wdata[7:0];
        REG_SYNC_V2:       cfg_nxt.sync_v2       = cfg_wdata[7:0];
        REG_PAYLOAD_LIMIT: cfg_nxt.payload_limit = cfg_wdata;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_v1       <= SYNC_V1_RESET;
      cfg_r.sync_v2       <= SYNC_V2_RESET;
      cfg_r.payload_limit <= PAYLOAD_LIMIT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: frame parser testbench
// Streams sync/length/CRC16 framed bytes into crc_checked_frame_parser, with
// good frames, corrupted CRCs, oversized lengths, cut-off frames and line
// noise, under several register settings. A scoreboard class parses the same
// bytes and checks every status item, field by field, in order.
// ----------------------------------------------------------------------------
module tb_top import cfp_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef enum logic [2:0] {
    AT_SYNC, AT_CMD, AT_SEQ, AT_LEN_LO, AT_LEN_HI, AT_PAYLOAD, AT_CRC_LO, AT_CRC_HI
  } parse_step_t;

  typedef enum logic [1:0] {FK_GOOD, FK_BAD_CRC, FK_LEN_ERR, FK_TRUNC} frame_kind_t;

  typedef struct packed {
    status_t     status;
    logic        version;
    logic [7:0]  command;
    logic [7:0]  seq_num;
    logic [15:0] length;
    logic [7:0]  pbyte;
    logic        pvalid;
    logic [15:0] pindex;
  } frame_report_t;

  class frame_scoreboard;
    logic [7:0]    sync_v1;
    logic [7:0]    sync_v2;
    logic [15:0]   len_limit;
    parse_step_t   step;
    logic          version;
    logic [7:0]    command;
    logic [7:0]    seq_num;
    logic [15:0]   length;
    logic [15:0]   count;
    logic [15:0]   crc;
    logic [7:0]    crc_lo;
    frame_report_t due_reports[$];
    int unsigned   errors;

    function new();
      sync_v1   = SYNC_V1_RESET;
      sync_v2   = SYNC_V2_RESET;
      len_limit = PAYLOAD_LIMIT_RESET;
      step      = AT_SYNC;
      version   = 1'b0;
      command   = '0;
      seq_num   = '0;
      length    = '0;
      count     = '0;
      crc       = CRC_INIT;
      crc_lo    = '0;
      errors    = 0;
    endfunction

    static function logic [15:0] crc_step(logic [15:0] crc_in, logic [7:0] b);
      logic [15:0] c;
      logic        fb;
      c = crc_in;
      for (int i = 7; i >= 0; i--) begin
        fb = c[15] ^ b[i];
        c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
      end
      return c;
    endfunction

    function void set_regs(logic [7:0] v1, logic [7:0] v2, logic [15:0] lim);
      sync_v1   = v1;
      sync_v2   = v2;
      len_limit = lim;
    endfunction

    function int unsigned pending();
      return due_reports.size();
    endfunction

    function void parse_byte(logic [7:0] b);
      frame_report_t r;
      status_t       st;
      r  = '0;
      st = ST_BUSY;
      case (step)
        AT_SYNC: begin
          if (b == sync_v1 || b == sync_v2) begin
            version  = (b == sync_v1) ? 1'b0 : 1'b1;
            command  = '0;
            seq_num  = '0;
            length   = '0;
            count    = '0;
            crc      = CRC_INIT;
            step     = AT_CMD;
          end
        end
        AT_CMD: begin
          command = b;
          crc     = crc_step(crc, b);
          step    = version ? AT_SEQ : AT_LEN_LO;
        end
        AT_SEQ: begin
          seq_num  = b;
          crc      = crc_step(crc, b);
          step     = AT_LEN_LO;
        end
        AT_LEN_LO: begin
          length = {8'h00, b};
          crc    = crc_step(crc, b);
          step   = AT_LEN_HI;
        end
        AT_LEN_HI: begin
          length = {b, length[7:0]};
          crc    = crc_step(crc, b);
          count  = '0;
          if (length > len_limit) begin
            st   = ST_LENERR;
            step = AT_SYNC;
          end else begin
            step = (length == 16'd0) ? AT_CRC_LO : AT_PAYLOAD;
          end
        end
        AT_PAYLOAD: begin
          r.pbyte  = b;
          r.pvalid = 1'b1;
          r.pindex = count;
          crc      = crc_step(crc, b);
          count    = count + 16'd1;
          if (count >= length || count == 16'd0) begin
            step = AT_CRC_LO;
          end
        end
        AT_CRC_LO: begin
          crc_lo = b;
          step   = AT_CRC_HI;
        end
        default: begin
          st   = ({b, crc_lo} == crc) ? ST_GOOD : ST_CRCERR;
          step = AT_SYNC;
        end
      endcase
      r.status   = st;
      r.version  = version;
      r.command  = command;
      r.seq_num  = seq_num;
      r.length   = length;
      due_reports.push_back(r);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_report(frame_report_t got);
      frame_report_t want;
      if (due_reports.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual status %0h",
                 $time, got.status);
        errors++;
        return;
      end
      want = due_reports.pop_front();
      compare_field("frame_status", want.status, got.status);
      compare_field("frame_version", want.version, got.version);
      compare_field("command_code", want.command, got.command);
      compare_field("sequence_number", want.seq_num, got.seq_num);
      compare_field("payload_length", want.length, got.length);
      compare_field("payload_byte", want.pbyte, got.pbyte);
      compare_field("payload_valid", want.pvalid, got.pvalid);
      compare_field("payload_index", want.pindex, got.pindex);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_SYNC_V1;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            in_data_byte = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [1:0]            out_frame_status;
  logic                  out_frame_version;
  logic [7:0]            out_command_code;
  logic [7:0]            out_sequence_number;
  logic [15:0]           out_payload_length;
  logic [7:0]            out_payload_byte;
  logic                  out_payload_valid;
  logic [15:0]           out_payload_index;

  frame_scoreboard sb;
  bit              steady = 1'b0;
  bit              hold_off_req = 1'b0;
  int unsigned     stuck_cycles = 0;

  crc_checked_frame_parser u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_data_byte        (in_data_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_frame_status    (out_frame_status),
    .out_frame_version   (out_frame_version),
    .out_command_code    (out_command_code),
    .out_sequence_number (out_sequence_number),
    .out_payload_length  (out_payload_length),
    .out_payload_byte    (out_payload_byte),
    .out_payload_valid   (out_payload_valid),
    .out_payload_index   (out_payload_index)
  );

  always #2 clk = ~clk;

  // check results first, then note the byte taken at the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        sb.check_report('{status:   status_t'(out_frame_status),
                          version:  out_frame_version,
                          command:  out_command_code,
                          seq_num:  out_sequence_number,
                          length:   out_payload_length,
                          pbyte:    out_payload_byte,
                          pvalid:   out_payload_valid,
                          pindex:   out_payload_index});
      end
      if (in_valid && in_ready) begin
        sb.parse_byte(in_data_byte);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: random back-pressure, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(0, 99) >= 9);
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    if (!steady && $urandom_range(0, 99) < 9) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic configure(input logic [7:0] v1, input logic [7:0] v2,
                           input logic [15:0] lim);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SYNC_V1;
    cfg_wdata <= {8'($urandom_range(0, 255)), v1};
    @(posedge clk);
    cfg_index <= REG_SYNC_V2;
    cfg_wdata <= {8'($urandom_range(0, 255)), v2};
    @(posedge clk);
    cfg_index <= REG_PAYLOAD_LIMIT;
    cfg_wdata <= lim;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_regs(v1, v2, lim);
  endtask

  task automatic send_frame(input frame_kind_t kind, input bit want_v2,
                            input logic [7:0] cmd, input logic [7:0] seq,
                            input logic [15:0] plen, output int unsigned sent);
    logic [7:0]  frame[$];
    logic [15:0] crc;
    bit          v2;
    v2 = want_v2 && (sb.sync_v1 != sb.sync_v2);
    frame.push_back(v2 ? sb.sync_v2 : sb.sync_v1);
    frame.push_back(cmd);
    if (v2) begin
      frame.push_back(seq);
    end
    frame.push_back(plen[7:0]);
    frame.push_back(plen[15:8]);
    if (kind != FK_LEN_ERR) begin
      for (int unsigned i = 0; i < plen; i++) begin
        frame.push_back(8'($urandom_range(0, 255)));
      end
      crc = CRC_INIT;
      for (int i = 1; i < frame.size(); i++) begin
        crc = frame_scoreboard::crc_step(crc, frame[i]);
      end
      if (kind == FK_BAD_CRC) begin
        crc ^= 16'($urandom_range(1, 65535));
      end
      frame.push_back(crc[7:0]);
      frame.push_back(crc[15:8]);
      if (kind == FK_TRUNC) begin
        frame = frame[0:$urandom_range(0, frame.size() - 2)];
      end
    end
    foreach (frame[i]) begin
      push_byte(frame[i]);
    end
    sent = frame.size();
  endtask

  task automatic run_traffic(input int unsigned n_items, input int unsigned hold_at);
    int unsigned count;
    int unsigned sent;
    int unsigned r;
    int unsigned lim;
    logic [15:0] plen;
    frame_kind_t kind;
    bit          held;
    count = 0;
    held  = 1'b0;
    while (count < n_items) begin
      if (hold_at != 0 && !held && count >= hold_at) begin
        hold_off_req = 1'b1;
        held         = 1'b1;
      end
      lim = sb.len_limit;
      r   = $urandom_range(0, 99);
      if (r < 8) begin
        repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
      end else begin
        kind = (r < 70) ? FK_GOOD : (r < 80) ? FK_BAD_CRC : (r < 88) ? FK_LEN_ERR : FK_TRUNC;
        if (kind == FK_LEN_ERR && lim == 65535) begin
          kind = FK_GOOD;
        end
        if (kind == FK_LEN_ERR) begin
          plen = ($urandom_range(0, 2) == 0) ? 16'(lim + 1) :
                 16'($urandom_range(lim + 1, 65535));
        end else begin
          r    = $urandom_range(0, 99);
          plen = (r < 60) ? 16'($urandom_range(0, 4)) :
                 (r < 95) ? 16'($urandom_range(5, 16)) : 16'($urandom_range(17, 48));
          if (plen > lim) begin
            plen = 16'(lim);
          end
        end
        send_frame(kind, bit'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), plen, sent);
        count += sent;
      end
    end
  endtask

  initial begin
    int unsigned sent;
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: ignored noise, both versions, field extremes, bad CRC, length error
    push_byte(8'h00);
    push_byte(8'hFF);
    send_frame(FK_GOOD, 1'b0, 8'hFF, 8'h00, 16'd0, sent);
    send_frame(FK_GOOD, 1'b1, 8'h00, 8'hFF, 16'd1, sent);
    send_frame(FK_BAD_CRC, 1'b0, 8'hA5, 8'h00, 16'd0, sent);
    send_frame(FK_LEN_ERR, 1'b1, 8'h5A, 8'h3C, 16'hFFFF, sent);

    run_traffic(300, 0);
    send_frame(FK_TRUNC, 1'b1, 8'h81, 8'h7E, 16'd3, sent);
    drain();

    // limit zero: only empty payloads pass
    configure(8'h00, 8'hFF, 16'd0);
    run_traffic(250, 60);
    drain();

    // equal sync bytes, maximum limit, no idling on either side
    configure(8'h5A, 8'h5A, 16'hFFFF);
    steady = 1'b1;
    run_traffic(250, 0);
    send_frame(FK_TRUNC, 1'b0, 8'h3C, 8'h00, 16'd5, sent);
    drain();
    steady = 1'b0;

    configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              16'($urandom_range(1, 20)));
    run_traffic(300, 0);
    drain();

    configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              16'($urandom_range(21, 300)));
    run_traffic(300, 0);
    drain();

    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/cfp_pkg.sv
hw/rtl/cfp_cfg_regs.sv
hw/rtl/crc_checked_frame_parser.sv
tb/tb_top.sv
